>>> hw/rtl/vertex_normal_averaging_assert.svh
// Assertion macros for the vertex normal averaging block.
`ifndef VERTEX_NORMAL_AVERAGING_ASSERT_SVH
`define VERTEX_NORMAL_AVERAGING_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VNA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define VNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/vna_pkg.sv
// Shared constants and widths for the vertex normal averaging block.
package vna_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COORD_W    = 24;
  localparam int SUM_W      = 24;
  localparam int NORM_W     = 16;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int CROSS_W    = 2 * EDGE_W + 1;
  localparam int MAG_LIMIT  = 30;
  localparam int SQ_W       = 2 * MAG_LIMIT + 2;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int LEN_W      = MAG_LIMIT + 1;
  localparam int FRAC_W     = 14;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int REM_W      = MAG_LIMIT + FRAC_W + 1;
  localparam int MUL_W      = 32;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

endpackage

>>> hw/rtl/vna_if.sv
// Valid/ready channel interfaces for commands and normal results.
interface vna_in_if import vna_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [ADDR_W-1:0]         vertex_a;
  logic [ADDR_W-1:0]         vertex_b;
  logic [ADDR_W-1:0]         vertex_c;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;

  modport source (output valid, command, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, command, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vna_out_if import vna_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;
  logic                     is_zero;

  modport source (output valid, normal_x, normal_y, normal_z, is_zero, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, is_zero, output ready);
endinterface

>>> hw/rtl/vertex_normal_averaging.sv
// Per-vertex mesh normals: coordinate and normal-sum memories with a shared normalizer.
// Commands are taken one at a time. A read delivers its result after normalizing its
// sum, or directly when the sum is zero; a triangle holds the block through the cross
// product, normalization and three sum updates, ends early when degenerate, and runs
// longer for the one-bit-per-cycle prescale of wide cross products. The time is set by
// the shared normalizer: a 32-step bit-serial square root per vector and a 15-step
// restoring divider per component, plus one shared 32x32 multiplier for the cross
// product and the squares. Sum updates for the three corners are serialized
// read-then-write through the sum memory. After reset the normal-sum memory is cleared
// one entry per cycle with the input channel held not ready. A finished read result
// waits in an output register while the next command is taken.
module vertex_normal_averaging import vna_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  vna_in_if.sink    in_ch,
  vna_out_if.source out_ch
);

`include "vertex_normal_averaging_assert.svh"

  typedef enum logic [15:0] {
    S_CLR   = 16'b0000_0000_0000_0001,
    S_IDLE  = 16'b0000_0000_0000_0010,
    S_RDB   = 16'b0000_0000_0000_0100,
    S_RDC   = 16'b0000_0000_0000_1000,
    S_CAP   = 16'b0000_0000_0001_0000,
    S_MUL   = 16'b0000_0000_0010_0000,
    S_RSUM  = 16'b0000_0000_0100_0000,
    S_NABS  = 16'b0000_0000_1000_0000,
    S_NSHR  = 16'b0000_0001_0000_0000,
    S_NSQ   = 16'b0000_0010_0000_0000,
    S_NSQRT = 16'b0000_0100_0000_0000,
    S_NDIVI = 16'b0000_1000_0000_0000,
    S_NDIV  = 16'b0001_0000_0000_0000,
    S_SRD   = 16'b0010_0000_0000_0000,
    S_SWR   = 16'b0100_0000_0000_0000,
    S_EMIT  = 16'b1000_0000_0000_0000
  } state_t;

  localparam logic signed [SUM_W:0]    SAT_HI   = (SUM_W+1)'((2 ** (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0]    SAT_LO   = (SUM_W+1)'(-(2 ** (SUM_W - 1)));
  localparam logic signed [NORM_W-1:0] NORM_POS = NORM_W'(2 ** FRAC_W);
  localparam logic signed [NORM_W-1:0] NORM_NEG = NORM_W'(-(2 ** FRAC_W));

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              out_valid_r;
  logic              accept;
  logic              emit;

  logic [ADDR_W-1:0] va_r, vb_r, vc_r;
  logic              is_read_r;
  logic [2:0]        k_r;
  logic [1:0]        corner_r;
  logic [ADDR_W-1:0] corner_addr;

  logic [3*COORD_W-1:0] coord_mem [MAX_POINTS];
  logic [3*COORD_W-1:0] coord_q_r;
  logic [ADDR_W-1:0]    coord_raddr;
  logic                 coord_we;
  logic [3*SUM_W-1:0]   sum_mem [MAX_POINTS];
  logic [3*SUM_W-1:0]   sum_q_r;
  logic [ADDR_W-1:0]    sum_raddr;
  logic                 sum_we;
  logic [ADDR_W-1:0]    sum_waddr;
  logic [3*SUM_W-1:0]   sum_wdata;

  logic signed [COORD_W-1:0] coord_q_s [3];
  logic signed [SUM_W-1:0]   sum_q_s [3];
  logic signed [SUM_W-1:0]   sat_lane [3];
  logic signed [COORD_W-1:0] pa_r [3];
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_r;

  logic signed [CROSS_W-1:0] v_r [3];
  logic [CROSS_W-1:0]        m_r [3];
  logic [2:0]                neg_r;
  logic                      vec_zero;
  logic                      shr_need;
  logic [MAG_LIMIT-1:0]      sel_m;
  logic                      sel_neg;

  logic [SQ_W-1:0] sq_r;
  logic [SQ_W-1:0] root_r;
  logic [SQ_W-1:0] root_nxt;
  logic [4:0]      j_r;
  logic [SQ_W:0]   bitv;
  logic [SQ_W:0]   trial;
  logic            take;

  logic [LEN_W-1:0]   len_r;
  logic [REM_W-1:0]   rem_r;
  logic [QUO_W-2:0]   q_r;
  logic [3:0]         dj_r;
  logic [REM_W-1:0]   dtrial;
  logic               dge;
  logic [QUO_W-1:0]   qfin;

  logic signed [NORM_W-1:0] n_r [3];
  logic                     zero_r;
  logic signed [NORM_W-1:0] out_n_r [3];
  logic                     out_zero_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign emit        = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid    = out_valid_r;
  assign out_ch.normal_x = out_n_r[0];
  assign out_ch.normal_y = out_n_r[1];
  assign out_ch.normal_z = out_n_r[2];
  assign out_ch.is_zero  = out_zero_r;

  always_comb begin
    case (corner_r)
      2'd0:    corner_addr = va_r;
      2'd1:    corner_addr = vb_r;
      default: corner_addr = vc_r;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coord_q_s[i] = signed'(coord_q_r[i*COORD_W +: COORD_W]);
      sum_q_s[i]   = signed'(sum_q_r[i*SUM_W +: SUM_W]);
    end
  end

  always_comb begin
    case (state_r)
      S_RDB:   coord_raddr = vb_r;
      S_RDC:   coord_raddr = vc_r;
      default: coord_raddr = in_ch.vertex_a;
    endcase
    sum_raddr = (state_r == S_SRD) ? corner_addr : in_ch.vertex_a;
    coord_we  = accept && (in_ch.command == CMD_LOAD);
  end

  always_comb begin
    logic signed [SUM_W:0] t;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t = (SUM_W+1)'(sum_q_s[i]) + (SUM_W+1)'(n_r[i]);
      if (t > SAT_HI) begin
        t = SAT_HI;
      end else if (t < SAT_LO) begin
        t = SAT_LO;
      end
      sat_lane[i] = t[SUM_W-1:0];
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = clr_addr_r;
    sum_wdata = '0;
    case (state_r)
      S_CLR: begin
        sum_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && (in_ch.command == CMD_LOAD)) begin
          sum_we    = 1'b1;
          sum_waddr = in_ch.vertex_a;
        end
      end
      S_SWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_addr;
        sum_wdata = {sat_lane[2], sat_lane[1], sat_lane[0]};
      end
      default: sum_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    coord_q_r <= coord_mem[coord_raddr];
    if (coord_we) begin
      coord_mem[in_ch.vertex_a] <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    end
  end

  always_ff @(posedge clk) begin
    sum_q_r <= sum_mem[sum_raddr];
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      case (k_r)
        3'd0: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[2]); end
        3'd1: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[1]); end
        3'd2: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[0]); end
        3'd3: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[2]); end
        3'd4: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[1]); end
        3'd5: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_NSQ) begin
      mul_a = signed'(MUL_W'(sel_m));
      mul_b = signed'(MUL_W'(sel_m));
    end
  end

  always_comb begin
    case (k_r[1:0])
      2'd0:    begin sel_m = m_r[0][MAG_LIMIT-1:0]; sel_neg = neg_r[0]; end
      2'd1:    begin sel_m = m_r[1][MAG_LIMIT-1:0]; sel_neg = neg_r[1]; end
      default: begin sel_m = m_r[2][MAG_LIMIT-1:0]; sel_neg = neg_r[2]; end
    endcase
    vec_zero = (v_r[0] == '0) && (v_r[1] == '0) && (v_r[2] == '0);
    shr_need = |((m_r[0] | m_r[1] | m_r[2]) >> MAG_LIMIT);
  end

  always_comb begin
    bitv     = (SQ_W+1)'(1) << {j_r, 1'b0};
    trial    = {1'b0, root_r} + bitv;
    take     = ({1'b0, sq_r} >= trial);
    root_nxt = take ? ((root_r >> 1) + bitv[SQ_W-1:0]) : (root_r >> 1);
    dtrial   = REM_W'(len_r) << dj_r;
    dge      = (rem_r >= dtrial);
    qfin     = {q_r, dge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (clr_addr_r == ADDR_W'(MAX_POINTS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_TRI:  state_nxt = S_RDB;
            CMD_READ: state_nxt = S_RSUM;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_RDB:   state_nxt = S_RDC;
      S_RDC:   state_nxt = S_CAP;
      S_CAP:   state_nxt = S_MUL;
      S_MUL:   if (k_r == 3'd6) state_nxt = S_NABS;
      S_RSUM:  state_nxt = S_NABS;
      S_NABS: begin
        if (vec_zero) begin
          state_nxt = is_read_r ? S_EMIT : S_IDLE;
        end else begin
          state_nxt = S_NSHR;
        end
      end
      S_NSHR:  if (!shr_need) state_nxt = S_NSQ;
      S_NSQ:   if (k_r == 3'd3) state_nxt = S_NSQRT;
      S_NSQRT: if (j_r == '0) state_nxt = S_NDIVI;
      S_NDIVI: state_nxt = S_NDIV;
      S_NDIV: begin
        if (dj_r == '0) begin
          if (k_r == 3'd2) begin
            state_nxt = is_read_r ? S_EMIT : S_SRD;
          end else begin
            state_nxt = S_NDIVI;
          end
        end
      end
      S_SRD:   state_nxt = S_SWR;
      S_SWR:   if (corner_r == 2'd2) state_nxt = S_IDLE; else state_nxt = S_SRD;
      S_EMIT:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_n_r    <= n_r;
      out_zero_r <= zero_r;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          va_r      <= in_ch.vertex_a;
          vb_r      <= in_ch.vertex_b;
          vc_r      <= in_ch.vertex_c;
          is_read_r <= (in_ch.command == CMD_READ);
          k_r       <= '0;
        end
      end
      S_RDB: pa_r <= coord_q_s;
      S_RDC: begin
        for (int i = 0; i < 3; i++) e1_r[i] <= EDGE_W'(coord_q_s[i]) - EDGE_W'(pa_r[i]);
      end
      S_CAP: begin
        for (int i = 0; i < 3; i++) e2_r[i] <= EDGE_W'(coord_q_s[i]) - EDGE_W'(pa_r[i]);
      end
      S_MUL: begin
        prod_r <= mul_a * mul_b;
        k_r    <= k_r + 1'b1;
        case (k_r)
          3'd1: v_r[0] <= signed'(prod_r[CROSS_W-1:0]);
          3'd2: v_r[0] <= v_r[0] - signed'(prod_r[CROSS_W-1:0]);
          3'd3: v_r[1] <= signed'(prod_r[CROSS_W-1:0]);
          3'd4: v_r[1] <= v_r[1] - signed'(prod_r[CROSS_W-1:0]);
          3'd5: v_r[2] <= signed'(prod_r[CROSS_W-1:0]);
          3'd6: v_r[2] <= v_r[2] - signed'(prod_r[CROSS_W-1:0]);
          default: v_r <= v_r;
        endcase
      end
      S_RSUM: begin
        for (int i = 0; i < 3; i++) v_r[i] <= CROSS_W'(sum_q_s[i]);
      end
      S_NABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= v_r[i][CROSS_W-1];
          m_r[i]   <= v_r[i][CROSS_W-1] ? CROSS_W'(-v_r[i]) : CROSS_W'(v_r[i]);
          n_r[i]   <= '0;
        end
        zero_r <= vec_zero;
        k_r    <= '0;
        sq_r   <= '0;
      end
      S_NSHR: begin
        if (shr_need) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end
      end
      S_NSQ: begin
        prod_r <= mul_a * mul_b;
        k_r    <= k_r + 1'b1;
        if (k_r != '0) begin
          sq_r <= sq_r + prod_r[SQ_W-1:0];
        end
        if (k_r == 3'd3) begin
          j_r    <= 5'(ROOT_STEPS);
          root_r <= '0;
        end
      end
      S_NSQRT: begin
        if (take) begin
          sq_r <= sq_r - trial[SQ_W-1:0];
        end
        root_r <= root_nxt;
        j_r    <= j_r - 1'b1;
        if (j_r == '0) begin
          len_r <= root_nxt[LEN_W-1:0];
          k_r   <= '0;
        end
      end
      S_NDIVI: begin
        rem_r <= REM_W'({sel_m, {FRAC_W{1'b0}}}) + REM_W'(len_r >> 1);
        q_r   <= '0;
        dj_r  <= 4'(QUO_W - 1);
      end
      S_NDIV: begin
        if (dge) begin
          rem_r <= rem_r - dtrial;
        end
        q_r  <= qfin[QUO_W-2:0];
        dj_r <= dj_r - 1'b1;
        if (dj_r == '0) begin
          n_r[k_r[1:0]] <= sel_neg ? -NORM_W'(qfin) : NORM_W'(qfin);
          k_r           <= k_r + 1'b1;
          corner_r      <= '0;
        end
      end
      S_SWR: corner_r <= corner_r + 1'b1;
      default: k_r <= k_r;
    endcase
  end

  `VNA_ASSERT(a_zero_means_null, out_valid_r && out_zero_r,
              (out_n_r[0] == '0) && (out_n_r[1] == '0) && (out_n_r[2] == '0),
              "zero flag with nonzero normal")
  `VNA_ASSERT(a_norm_range, out_valid_r,
              (out_n_r[0] <= NORM_POS) && (out_n_r[0] >= NORM_NEG) &&
              (out_n_r[1] <= NORM_POS) && (out_n_r[1] >= NORM_NEG) &&
              (out_n_r[2] <= NORM_POS) && (out_n_r[2] >= NORM_NEG),
              "normal component out of unit range")
  `VNA_ASSERT_NEXT(a_div_rem, (state_r == S_NDIV) && (dj_r == '0),
                   rem_r < REM_W'(len_r), "divider remainder not below divisor")
  `VNA_ASSERT_NEXT(a_rmw_order, state_r == S_SRD, state_r == S_SWR,
                   "sum read not followed by its write back")

endmodule
